// ===== sv/touch_level_accumulate_normalize_macros.svh =====
// Assertion macros for the touch level block.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef TOUCH_LEVEL_ACCUMULATE_NORMALIZE_MACROS_SVH
`define TOUCH_LEVEL_ACCUMULATE_NORMALIZE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define TLAN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch level check failed");
// Next-cycle implication, disabled during reset
`define TLAN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch level check failed");
`else
`define TLAN_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLAN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/tlan_pkg.sv =====
// Package for the touch level block: field widths, register indexes, defaults.
// Depends on nothing; imported by the design, the checker and the testbench top.
package tlan_pkg;

   localparam int DEF_SAMPLE_BITS = 10;
   localparam int SUM_W           = 18;
   localparam int CNT_W           = 8;
   localparam int THR_W           = 16;
   localparam int NORM_W          = 8;
   // level * 255 needs level width plus eight bits
   localparam int NUM_W           = SUM_W + NORM_W;
   localparam int QBIT_W          = 3;
   localparam int RSP_DATA_W      = ((SUM_W + NORM_W + 7) / 8) * 8;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = SUM_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GROUP_SIZE      = 2'd0,
      CSR_TOUCH_THRESHOLD = 2'd1,
      CSR_PEAK_START      = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

endpackage

// ===== sv/touch_level_accumulate_normalize.sv =====
// Touch level: one request per cycle while accumulating; a request that closes a
// group keeps the block busy (accumulate, threshold, scale, 8 divide steps,
// output load), and the divide runs on the shared 26-bit subtractor.
// Results go to an output register, so a new request is taken while it waits.
// Reset (synchronous, active high): group size 1, threshold 0, peak 1, empty sum.
// Depends on tlan_pkg and touch_level_accumulate_normalize_macros.svh.
`include "touch_level_accumulate_normalize_macros.svh"

module touch_level_accumulate_normalize
   import tlan_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [SAMPLE_BITS-1:0] adc_sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [17:0] level, [25:18] normalized
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEVEL,
      S_SCALE,
      S_DIV,
      S_DONE
   } state_type;

   localparam int CNT_X_W = CNT_W + 1;

   state_type           state_ff,       state_in;
   logic [CNT_W-1:0]    group_size_ff,  group_size_in;
   logic [THR_W-1:0]    threshold_ff,   threshold_in;
   logic [SUM_W-1:0]    peak_ff,        peak_in;
   logic [SUM_W-1:0]    sum_ff,         sum_in;
   logic [CNT_W-1:0]    count_ff,       count_in;
   logic [SUM_W-1:0]    level_ff,       level_in;
   logic [NUM_W-1:0]    rem_ff,         rem_in;
   logic [NUM_W-1:0]    div_ff,         div_in;
   logic [NORM_W-1:0]   quot_ff,        quot_in;
   logic [QBIT_W-1:0]   qbit_ff,        qbit_in;
   logic                rsp_valid_ff,   rsp_valid_in;
   logic [SUM_W-1:0]    rsp_level_ff,   rsp_level_in;
   logic [NORM_W-1:0]   rsp_norm_ff,    rsp_norm_in;

   logic [SAMPLE_BITS-1:0] sample;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [CNT_X_W-1:0]     count_next;
   logic [CNT_X_W-1:0]     eff_size;
   logic                   group_end;
   logic                   req_fire;
   logic                   rsp_free;

   // Shared subtract unit
   logic [NUM_W-1:0]       alu_a, alu_b;
   logic [NUM_W:0]         alu_diff;
   logic                   alu_borrow;

   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(sample);
   assign sum_sat    = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
   assign count_next = {1'b0, count_ff} + CNT_X_W'(1);
   assign eff_size   = (group_size_ff == '0) ? CNT_X_W'(1 << CNT_W)
                                             : {1'b0, group_size_ff};
   assign group_end  = !(count_next < eff_size);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      unique case (state_ff)
         S_LEVEL: begin
            alu_a = NUM_W'(sum_ff);
            alu_b = NUM_W'(threshold_ff);
         end
         S_SCALE: begin
            alu_a = {level_ff, {NORM_W{1'b0}}};
            alu_b = NUM_W'(level_ff);
         end
         S_DIV: begin
            alu_a = rem_ff;
            alu_b = div_ff;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_diff[NUM_W];

   always_comb begin
      state_in      = state_ff;
      group_size_in = group_size_ff;
      threshold_in  = threshold_ff;
      peak_in       = peak_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      level_in      = level_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quot_in       = quot_ff;
      qbit_in       = qbit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_norm_in   = rsp_norm_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sum_in = sum_sat;
               if (group_end) begin
                  count_in = '0;
                  state_in = S_LEVEL;
               end else begin
                  count_in = count_next[CNT_W-1:0];
               end
            end
         end
         S_LEVEL: begin
            // clamp at zero, then raise the peak
            level_in = alu_borrow ? '0 : alu_diff[SUM_W-1:0];
            if (!alu_borrow && (alu_diff[SUM_W-1:0] > peak_ff)) begin
               peak_in = alu_diff[SUM_W-1:0];
            end
            sum_in   = '0;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            rem_in   = alu_diff[NUM_W-1:0];
            div_in   = NUM_W'({peak_ff, {(NORM_W-1){1'b0}}});
            quot_in  = '0;
            qbit_in  = QBIT_W'(NORM_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            // one quotient bit a cycle, divisor walks down from peak << 7
            if (!alu_borrow) begin
               rem_in = alu_diff[NUM_W-1:0];
            end
            quot_in = {quot_ff[NORM_W-2:0], !alu_borrow};
            div_in  = div_ff >> 1;
            qbit_in = qbit_ff - QBIT_W'(1);
            if (qbit_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_norm_in  = quot_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GROUP_SIZE:      group_size_in = csr_data[CNT_W-1:0];
            CSR_TOUCH_THRESHOLD: threshold_in  = csr_data[THR_W-1:0];
            CSR_PEAK_START: begin
               peak_in = (csr_data == '0) ? SUM_W'(1) : csr_data;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         group_size_ff <= CNT_W'(1);
         threshold_ff  <= '0;
         peak_ff       <= SUM_W'(1);
         sum_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         group_size_ff <= group_size_in;
         threshold_ff  <= threshold_in;
         peak_ff       <= peak_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      level_ff     <= level_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      quot_ff      <= quot_in;
      qbit_ff      <= qbit_in;
      rsp_level_ff <= rsp_level_in;
      rsp_norm_ff  <= rsp_norm_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_norm_ff, rsp_level_ff});

   `TLAN_ASSERT_IMP(a_peak_nonzero, clock, reset, 1'b1, peak_ff != '0)
   `TLAN_ASSERT_IMP(a_level_below_peak, clock, reset, state_ff == S_DONE, level_ff <= peak_ff)
   `TLAN_ASSERT_NEXT(a_div_done, clock, reset, state_ff == S_DIV && qbit_ff == '0, state_ff == S_DONE)
   `TLAN_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE))

endmodule

// ===== tb/sv/touch_level_checker.sv =====
`timescale 1ns / 100ps
// Checker for the touch level block: watches the request, result and register
// channels, predicts each level reading and compares it. Depends on tlan_pkg.
module touch_level_checker
   import tlan_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [SAMPLE_BITS-1:0] adc_sample
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // [17:0] level, [25:18] normalized
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     error_count,
   output int                     pending_results
);

   localparam int unsigned SUM_LIMIT  = (1 << SUM_W) - 1;
   localparam int unsigned FULL_SCALE = 255;

   // packed so that level lands in the low bits, as on the result bus
   typedef struct packed {
      logic [NORM_W-1:0] normalized;
      logic [SUM_W-1:0]  level;
   } touch_reading_type;

   logic [CNT_W-1:0] group_size_q;
   logic [THR_W-1:0] threshold_q;
   logic [SUM_W-1:0] peak_q;
   logic [SUM_W-1:0] sum_q;
   logic [CNT_W-1:0] count_q;

   touch_reading_type expected_readings[$];

   initial begin
      error_count     = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Add one sample to the open group; on group end produce the reading.
   function automatic bit accumulate_sample(input logic [SAMPLE_BITS-1:0] sample,
                                            output touch_reading_type reading);
      int unsigned span;
      int unsigned total;
      int unsigned seen;
      int unsigned lvl;
      int unsigned scaled;
      reading = '0;
      span  = (group_size_q == 0) ? 256 : group_size_q;
      total = sum_q + sample;
      if (total > SUM_LIMIT)
         total = SUM_LIMIT;
      seen = count_q + 1;
      if (seen < span) begin
         sum_q   = total[SUM_W-1:0];
         count_q = seen[CNT_W-1:0];
         return 1'b0;
      end
      sum_q   = '0;
      count_q = '0;
      lvl = (total > threshold_q) ? total - threshold_q : 0;
      if (lvl > peak_q)
         peak_q = lvl[SUM_W-1:0];
      if (peak_q == 0)
         peak_q = 1;
      scaled = (lvl * FULL_SCALE) / peak_q;
      if (scaled > FULL_SCALE)
         scaled = FULL_SCALE;
      reading.level      = lvl[SUM_W-1:0];
      reading.normalized = scaled[NORM_W-1:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      touch_reading_type got;
      touch_reading_type want;
      touch_reading_type fresh;
      if (reset) begin
         group_size_q = 1;
         threshold_q  = '0;
         peak_q       = 1;
         sum_q        = '0;
         count_q      = '0;
         expected_readings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = touch_reading_type'(rsp_tdata[SUM_W+NORM_W-1:0]);
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected result, level", got.level, -1);
            end else begin
               want = expected_readings.pop_front();
               if (got.level !== want.level)
                  report_mismatch("level", got.level, want.level);
               if (got.normalized !== want.normalized)
                  report_mismatch("normalized", got.normalized, want.normalized);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_GROUP_SIZE:      group_size_q = csr_data[CNT_W-1:0];
               CSR_TOUCH_THRESHOLD: threshold_q  = csr_data[THR_W-1:0];
               CSR_PEAK_START: begin
                  // zero would be a zero divisor: load one instead
                  peak_q = (csr_data == '0) ? SUM_W'(1) : csr_data;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (accumulate_sample(req_tdata[SAMPLE_BITS-1:0], fresh))
               expected_readings.push_back(fresh);
         end
      end
      pending_results = expected_readings.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the touch level testbench: clock, reset, request, register and result
// stimulus with random gaps and stalls. Depends on tlan_pkg and touch_level_checker.
module tb_top;
   import tlan_pkg::*;

   localparam int SAMPLE_BITS   = DEF_SAMPLE_BITS;
   localparam int REQ_W         = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
   localparam int IDLE_PCT      = 27;
   localparam int SETTLE_CYCLES = 20;
   localparam int RX_HOLD       = 200;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int LIMIT_NS      = 5_000_000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     error_count;
   int                     pending_results;

   bit steady;        // no gaps and no stalls while set
   bit hold_request;  // ask the receiver for one long hold-off

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   touch_level_accumulate_normalize #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   touch_level_checker #(.SAMPLE_BITS(SAMPLE_BITS)) level_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   initial begin
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every expected reading, then let the block go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return SAMPLE_MAX;
         2:       return SAMPLE_BITS'(1 << $urandom_range(0, SAMPLE_BITS - 1));
         default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   initial begin
      logic [CNT_W-1:0]      gsize;
      logic [THR_W-1:0]      thr;
      logic [CSR_DATA_W-1:0] pstart;
      int                    span;
      int                    count;
      int                    sent;
      int                    phase;
      int                    waited;
      bit                    write_thr;
      bit                    write_peak;
      bit                    all_max;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_GROUP_SIZE;
      csr_data     = '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: single-sample groups, no threshold, peak of one
      send_sample(0);
      send_sample(SAMPLE_MAX);
      send_sample(511);
      settle();
      // below threshold clamps to zero
      write_reg(CSR_TOUCH_THRESHOLD, 600);
      send_sample(500);
      send_sample(SAMPLE_MAX);
      settle();
      // peak start of zero loads one
      write_reg(CSR_PEAK_START, 0);
      send_sample(SAMPLE_MAX);
      settle();
      // unused index is ignored
      write_reg(CSR_UNUSED, '1);
      send_sample(5);
      settle();
      write_reg(CSR_PEAK_START, 100000);
      write_reg(CSR_TOUCH_THRESHOLD, 0);
      send_sample(777);
      settle();
      // raise the group size, then lower it in the middle of a group
      write_reg(CSR_GROUP_SIZE, 5);
      send_sample(10'h2AA);
      send_sample(10'h155);
      send_sample(SAMPLE_MAX);
      settle();
      write_reg(CSR_GROUP_SIZE, 2);
      send_sample(1);
      settle();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         all_max    = 1'b0;
         write_thr  = 1'b1;
         write_peak = 1'b0;
         case (phase)
            0: begin
               // groups of 255 full-scale samples: a high level, near the top of the range
               gsize      = 8'd255;
               thr        = '0;
               pstart     = '1;
               write_peak = 1'b1;
               all_max    = 1'b1;
               count      = 255;
            end
            1: begin
               // size zero means 256 samples; largest threshold
               gsize = '0;
               thr   = '1;
               count = 256 + $urandom_range(0, 3);
            end
            2: begin
               steady = 1'b1;
               gsize  = CNT_W'($urandom_range(1, 4));
               thr    = THR_W'($urandom_range(0, 1500));
               count  = 120;
            end
            3: begin
               // single-sample groups while the receiver holds off
               gsize        = 8'd1;
               thr          = THR_W'($urandom_range(0, 300));
               count        = 80;
               hold_request = 1'b1;
            end
            default: begin
               case ($urandom_range(0, 19))
                  0:       gsize = '0;
                  1:       gsize = 8'd255;
                  2, 3, 4: gsize = CNT_W'($urandom_range(9, 40));
                  default: gsize = CNT_W'($urandom_range(1, 8));
               endcase
               span  = (gsize == 0) ? 256 : int'(gsize);
               count = (span > 40) ? span + $urandom_range(0, 3) : $urandom_range(20, 80);
               case ($urandom_range(0, 5))
                  0:       thr = '0;
                  1:       thr = '1;
                  default: thr = THR_W'($urandom_range(0,
                                    (span * 400 > 65535) ? 65535 : span * 400));
               endcase
               write_thr = ($urandom_range(0, 9) < 7);
               case ($urandom_range(0, 5))
                  0: begin
                     pstart     = '0;
                     write_peak = 1'b1;
                  end
                  1: begin
                     pstart     = '1;
                     write_peak = 1'b1;
                  end
                  2: begin
                     pstart     = CSR_DATA_W'($urandom_range(1, (1 << SUM_W) - 1));
                     write_peak = 1'b1;
                  end
                  default: write_peak = 1'b0;
               endcase
            end
         endcase
         write_reg(CSR_GROUP_SIZE, CSR_DATA_W'(gsize));
         if (write_thr)
            write_reg(CSR_TOUCH_THRESHOLD, CSR_DATA_W'(thr));
         if (write_peak)
            write_reg(CSR_PEAK_START, pstart);
         repeat (count) begin
            send_sample(all_max ? SAMPLE_MAX : pick_sample());
            sent++;
         end
         settle();
         steady = 1'b0;
         phase++;
      end

      req_tvalid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (pending_results != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results != 0) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (error_count == 0)
            $display("DONE: 0 errors");
         else
            $display("DONE: errors detected");
         $finish;
      end
   end

endmodule
